// ===== hdl/cpc_pkg.sv =====
// Shared types, constants and helpers for the coverage pixel to coordinate block.
package cpc_pkg;

	localparam int TableEntries = 32;
	localparam int KeyW = 24;
	localparam int LvlW = 12;
	localparam int PosW = 13;
	localparam int SizeW = 14;
	localparam int AddrW = 5;
	localparam int DataW = 32;
	localparam int LonProdW = PosW + 32;
	localparam int LatProdW = PosW + 31;

	localparam logic CmdLoad = 1'b0;
	localparam logic CmdPixel = 1'b1;

	localparam logic signed [LvlW-1:0] UnmatchedLevel = -12'sd1200;
	localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
	localparam longint LonLimit = 64'sd1800000000;
	localparam longint LatLimit = 64'sd900000000;

	typedef enum logic [2:0] {
		StPassed = 3'd0,
		StBelow  = 3'd1,
		StStored = 3'd2,
		StFull   = 3'd3,
		StEmpty  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		RegThreshold = 3'd0,
		RegLonOrigin = 3'd1,
		RegLonStep   = 3'd2,
		RegLatOrigin = 3'd3,
		RegLatStep   = 3'd4,
		RegColumns   = 3'd5,
		RegRows      = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [LvlW-1:0] thr;
		logic signed [31:0]     lon_origin;
		logic [31:0]            lon_step;
		logic signed [30:0]     lat_origin;
		logic [30:0]            lat_step;
		logic [SizeW-1:0]       cols;
		logic [SizeW-1:0]       rows;
	} cfg_t;

	typedef struct packed {
		logic                   vld;
		logic                   cmd;
		logic [KeyW-1:0]        key;
		logic signed [LvlW-1:0] lvl;
		logic [PosW-1:0]        row;
		logic [PosW-1:0]        col;
		logic                   hit;
		logic                   any;
		logic [KeyW-1:0]        best_key;
		logic signed [LvlW-1:0] best_lvl;
	} word_t;

	function automatic logic near_ch(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] d;
		d = {1'b0, a} - {1'b0, b};
		return (d == 9'd0) || (d == 9'd1) || (d == 9'h1FF);
	endfunction

endpackage

// ===== hdl/cpc_regs.sv =====
// APB configuration registers.
module cpc_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [cpc_pkg::AddrW-1:0] paddr,
	input  logic [cpc_pkg::DataW-1:0] pwdata,
	output logic [cpc_pkg::DataW-1:0] prdata,
	output logic                      pready,
	output cpc_pkg::cfg_t             cfg
);
	import cpc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr        <= -12'sd1200;
			cfg_q.lon_origin <= '0;
			cfg_q.lon_step   <= '0;
			cfg_q.lat_origin <= '0;
			cfg_q.lat_step   <= '0;
			cfg_q.cols       <= 14'd4096;
			cfg_q.rows       <= 14'd4096;
		end else if (wr) begin
			case (idx)
				RegThreshold: cfg_q.thr        <= pwdata[LvlW-1:0];
				RegLonOrigin: cfg_q.lon_origin <= pwdata;
				RegLonStep:   cfg_q.lon_step   <= pwdata;
				RegLatOrigin: cfg_q.lat_origin <= pwdata[30:0];
				RegLatStep:   cfg_q.lat_step   <= pwdata[30:0];
				RegColumns:   cfg_q.cols       <= pwdata[SizeW-1:0];
				RegRows:      cfg_q.rows       <= pwdata[SizeW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			RegThreshold: prdata = {{(DataW-LvlW){1'b0}}, cfg_q.thr};
			RegLonOrigin: prdata = cfg_q.lon_origin;
			RegLonStep:   prdata = cfg_q.lon_step;
			RegLatOrigin: prdata = {1'b0, cfg_q.lat_origin};
			RegLatStep:   prdata = {1'b0, cfg_q.lat_step};
			RegColumns:   prdata = {{(DataW-SizeW){1'b0}}, cfg_q.cols};
			RegRows:      prdata = {{(DataW-SizeW){1'b0}}, cfg_q.rows};
			default:      prdata = '0;
		endcase
	end

endmodule

// ===== hdl/cpc_raster.sv =====
// Raster row and column position counters.
module cpc_raster (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic                     frame_start,
	input  cpc_pkg::cfg_t            cfg,
	output logic [cpc_pkg::PosW-1:0] row,
	output logic [cpc_pkg::PosW-1:0] col
);
	import cpc_pkg::*;

	logic [PosW-1:0] row_q, col_q;
	logic            col_wrap, row_wrap;

	assign row = frame_start ? '0 : row_q;
	assign col = frame_start ? '0 : col_q;

	assign col_wrap = ({1'b0, col} + SizeW'(1) >= cfg.cols) || (col == PosMax);
	assign row_wrap = ({1'b0, row} + SizeW'(1) >= cfg.rows) || (row == PosMax);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (step) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row + PosW'(1);
			end else begin
				col_q <= col + PosW'(1);
				row_q <= row;
			end
		end
	end

endmodule

// ===== hdl/cpc_cell.sv =====
// One table cell: holds one colour entry and updates the word passing through.
module cpc_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  cpc_pkg::word_t word_i,
	output cpc_pkg::word_t word_o
);
	import cpc_pkg::*;

	logic                   ent_vld_q;
	logic [KeyW-1:0]        ent_key_q;
	logic signed [LvlW-1:0] ent_lvl_q;
	logic                   vld_q;
	word_t                  word_q;
	word_t                  nxt;
	logic                   wr_new, wr_lvl, match;

	assign match = near_ch(word_i.key[23:16], ent_key_q[23:16]) &&
		near_ch(word_i.key[15:8], ent_key_q[15:8]) &&
		near_ch(word_i.key[7:0], ent_key_q[7:0]);

	always_comb begin
		nxt    = word_i;
		wr_new = 1'b0;
		wr_lvl = 1'b0;
		if (word_i.vld) begin
			if (word_i.cmd == CmdLoad) begin
				if (!word_i.hit) begin
					if (ent_vld_q && (ent_key_q == word_i.key)) begin
						wr_lvl  = 1'b1;
						nxt.hit = 1'b1;
					end else if (!ent_vld_q) begin
						wr_new  = 1'b1;
						nxt.hit = 1'b1;
					end
				end
			end else if (ent_vld_q) begin
				nxt.any = 1'b1;
				if (match && (!word_i.hit || (ent_key_q < word_i.best_key))) begin
					nxt.hit      = 1'b1;
					nxt.best_key = ent_key_q;
					nxt.best_lvl = ent_lvl_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= 1'b0;
			ent_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= word_i.vld;
			if (wr_new) begin
				ent_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_q <= nxt;
			if (wr_new) begin
				ent_key_q <= word_i.key;
			end
			if (wr_new || wr_lvl) begin
				ent_lvl_q <= word_i.lvl;
			end
		end
	end

	always_comb begin
		word_o     = word_q;
		word_o.vld = vld_q;
	end

endmodule

// ===== hdl/cpc_tail.sv =====
// Coordinate multiply, saturation, status and output register.
module cpc_tail (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cpc_pkg::word_t                  word_i,
	input  cpc_pkg::cfg_t                   cfg,
	output logic                            adv,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      status,
	output logic signed [cpc_pkg::LvlW-1:0] level,
	output logic signed [31:0]              longitude,
	output logic signed [30:0]              latitude,
	output logic [cpc_pkg::PosW-1:0]        pixel_row,
	output logic [cpc_pkg::PosW-1:0]        pixel_column
);
	import cpc_pkg::*;

	localparam int LonSumW = LonProdW + 2;
	localparam int LatSumW = LatProdW + 2;
	localparam logic signed [LonSumW-1:0] LonHi = LonSumW'(LonLimit);
	localparam logic signed [LonSumW-1:0] LonLo = -LonSumW'(LonLimit);
	localparam logic signed [LatSumW-1:0] LatHi = LatSumW'(LatLimit);
	localparam logic signed [LatSumW-1:0] LatLo = -LatSumW'(LatLimit);

	logic                   vld_s1;
	word_t                  word_s1;
	logic [LonProdW-1:0]    plon_s1;
	logic [LatProdW-1:0]    plat_s1;

	logic                   out_valid_q;
	status_t                status_q;
	logic signed [LvlW-1:0] level_q;
	logic signed [31:0]     lon_q;
	logic signed [30:0]     lat_q;
	logic [PosW-1:0]        row_q, col_q;

	logic                   take;
	logic signed [LonSumW-1:0] lon_sum, lon_c;
	logic signed [LatSumW-1:0] lat_sum, lat_c;
	logic signed [LvlW-1:0] lvl_sel;
	status_t                st_nxt;

	assign take = !out_valid_q || !out_stall;
	assign adv  = take || !vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= word_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s1 <= word_i;
			plon_s1 <= LonProdW'(word_i.col) * LonProdW'(cfg.lon_step);
			plat_s1 <= LatProdW'(word_i.row) * LatProdW'(cfg.lat_step);
		end
	end

	always_comb begin
		lon_sum = {{(LonSumW-32){cfg.lon_origin[31]}}, cfg.lon_origin} + {2'b00, plon_s1};
		lat_sum = {{(LatSumW-31){cfg.lat_origin[30]}}, cfg.lat_origin} - {2'b00, plat_s1};
		if (lon_sum > LonHi) begin
			lon_c = LonHi;
		end else if (lon_sum < LonLo) begin
			lon_c = LonLo;
		end else begin
			lon_c = lon_sum;
		end
		if (lat_sum > LatHi) begin
			lat_c = LatHi;
		end else if (lat_sum < LatLo) begin
			lat_c = LatLo;
		end else begin
			lat_c = lat_sum;
		end
		lvl_sel = word_s1.hit ? word_s1.best_lvl : UnmatchedLevel;
		if (!word_s1.any) begin
			st_nxt = StEmpty;
		end else if (lvl_sel >= cfg.thr) begin
			st_nxt = StPassed;
		end else begin
			st_nxt = StBelow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (word_s1.cmd == CmdLoad) begin
				status_q <= word_s1.hit ? StStored : StFull;
				level_q  <= word_s1.lvl;
				lon_q    <= '0;
				lat_q    <= '0;
				row_q    <= '0;
				col_q    <= '0;
			end else begin
				status_q <= st_nxt;
				level_q  <= lvl_sel;
				lon_q    <= lon_c[31:0];
				lat_q    <= lat_c[30:0];
				row_q    <= word_s1.row;
				col_q    <= word_s1.col;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign level        = level_q;
	assign longitude    = lon_q;
	assign latitude     = lat_q;
	assign pixel_row    = row_q;
	assign pixel_column = col_q;

endmodule

// ===== hdl/coverage_pixel_to_coordinate_top.sv =====
// Top level of the coverage pixel classifier and coordinate generator.
//
// Input channel (in_valid/in_stall): one word per cycle unless stalled.
// command 0 loads a colour with entry_level into the table; command 1
// classifies a raster pixel. Output channel (out_valid/out_stall): exactly
// one result word per input word, in order: status, level, longitude,
// latitude, pixel_row, pixel_column. Throughput is one word per cycle when
// no stall holds it. A word passes 34 register stages: one in each of the
// 32 table cells, one for the coordinate multiplies and one for the output
// register. The first is loaded at the accepting edge.
// The table lives in the cell chain; each word visits every cell in turn, so
// loads and pixels see the table in arrival order.
// Reset clears the table, the raster position and all in-flight words, and
// loads the configuration reset values. When out_stall holds a result, the
// chain moves until a finished word reaches the tail, then in_stall rises. The
// user must write configuration over APB while the block is idle (unchecked).
module coverage_pixel_to_coordinate_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cpc_pkg::AddrW-1:0]       paddr,
	input  logic [cpc_pkg::DataW-1:0]       pwdata,
	output logic [cpc_pkg::DataW-1:0]       prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic [7:0]                      red,
	input  logic [7:0]                      green,
	input  logic [7:0]                      blue,
	input  logic signed [cpc_pkg::LvlW-1:0] entry_level,
	input  logic                            frame_start,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      status,
	output logic signed [cpc_pkg::LvlW-1:0] level,
	output logic signed [31:0]              longitude,
	output logic signed [30:0]              latitude,
	output logic [cpc_pkg::PosW-1:0]        pixel_row,
	output logic [cpc_pkg::PosW-1:0]        pixel_column
);
	import cpc_pkg::*;

	cfg_t            cfg;
	logic            adv, accept;
	logic [PosW-1:0] row, col;
	word_t           head;
	word_t           chain [TableEntries+1];

	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	cpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cpc_raster u_raster (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept && (command == CmdPixel)),
		.frame_start (frame_start),
		.cfg         (cfg),
		.row         (row),
		.col         (col)
	);

	always_comb begin
		head.vld      = accept;
		head.cmd      = command;
		head.key      = {red, green, blue};
		head.lvl      = entry_level;
		head.row      = row;
		head.col      = col;
		head.hit      = 1'b0;
		head.any      = 1'b0;
		head.best_key = '0;
		head.best_lvl = '0;
	end

	assign chain[0] = head;

	for (genvar i = 0; i < TableEntries; i++) begin : g_cell
		cpc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.word_i (chain[i]),
			.word_o (chain[i+1])
		);
	end

	cpc_tail u_tail (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_i       (chain[TableEntries]),
		.cfg          (cfg),
		.adv          (adv),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.level        (level),
		.longitude    (longitude),
		.latitude     (latitude),
		.pixel_row    (pixel_row),
		.pixel_column (pixel_column)
	);

endmodule
